// ----- sv/bcar_pkg.sv -----
// Shared types, constants and helper functions for the button counter with
// accelerating repeat. Used by every module of the block; depends on nothing.
package bcar_pkg;

    localparam int CfgRegs   = 8;
    localparam int RegW      = 16;
    localparam int TimeW     = 32;
    localparam int CountW    = 6;
    localparam int HoldW     = 5;
    localparam int SegW      = 7;
    localparam int DigitW    = 4;
    localparam int AddrW     = 5;
    localparam int DataW     = 32;
    localparam int InTdataW  = 8;
    localparam int OutTdataW = 24;

    localparam logic [HoldW-1:0]  HoldMax  = 5'd31;
    localparam logic [CountW:0]   CountMax = 7'd63;

    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_HOLD_DELAY   = 3'd1,
        REG_REPEAT_FIRST = 3'd2,
        REG_REPEAT_SLOW  = 3'd3,
        REG_REPEAT_MID   = 3'd4,
        REG_REPEAT_QUICK = 3'd5,
        REG_REPEAT_FAST  = 3'd6,
        REG_REPEAT_TOP   = 3'd7
    } bcar_reg_idx_t;

    typedef struct packed {
        logic [RegW-1:0] debounce_ms;
        logic [RegW-1:0] hold_delay_ms;
        logic [RegW-1:0] repeat_first_ms;
        logic [RegW-1:0] repeat_slow_ms;
        logic [RegW-1:0] repeat_mid_ms;
        logic [RegW-1:0] repeat_quick_ms;
        logic [RegW-1:0] repeat_fast_ms;
        logic [RegW-1:0] repeat_top_ms;
    } bcar_cfg_t;

    typedef struct packed {
        logic valid;
        logic button_level;
    } bcar_tick_t;

    function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] digit);
        logic [SegW-1:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [DigitW-1:0] tens_of(input logic [CountW-1:0] value);
        logic [DigitW-1:0] tens;
        if (value >= 6'd60) begin
            tens = 4'd6;
        end else if (value >= 6'd50) begin
            tens = 4'd5;
        end else if (value >= 6'd40) begin
            tens = 4'd4;
        end else if (value >= 6'd30) begin
            tens = 4'd3;
        end else if (value >= 6'd20) begin
            tens = 4'd2;
        end else if (value >= 6'd10) begin
            tens = 4'd1;
        end else begin
            tens = 4'd0;
        end
        return tens;
    endfunction

    function automatic logic [DigitW-1:0] ones_of(input logic [CountW-1:0] value);
        logic [CountW-1:0] tens_part;
        logic [CountW-1:0] rest;
        tens_part = {{(CountW-DigitW){1'b0}}, tens_of(value)} * 6'd10;
        rest      = value - tens_part;
        return rest[DigitW-1:0];
    endfunction

endpackage

// ----- sv/bcar_cfg_regs.sv -----
// APB-style register file holding the debounce, hold and repeat intervals.
// Depends on bcar_pkg for the register map and the configuration struct.
module bcar_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bcar_pkg::AddrW-1:0] paddr,
    input  logic [bcar_pkg::DataW-1:0] pwdata,
    output logic [bcar_pkg::DataW-1:0] prdata,
    output logic                      pready,
    output bcar_pkg::bcar_cfg_t       cfg
);
    import bcar_pkg::*;

    bcar_cfg_t     cfg_reg;
    bcar_cfg_t     cfg_next;
    bcar_reg_idx_t idx;
    logic [RegW-1:0] wdata;
    logic [RegW-1:0] rdata;
    logic          wr_en;

    assign pready = 1'b1;
    assign idx    = bcar_reg_idx_t'(paddr[AddrW-1:2]);
    assign wdata  = pwdata[RegW-1:0];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DEBOUNCE:     cfg_next.debounce_ms     = wdata;
                REG_HOLD_DELAY:   cfg_next.hold_delay_ms   = wdata;
                REG_REPEAT_FIRST: cfg_next.repeat_first_ms = wdata;
                REG_REPEAT_SLOW:  cfg_next.repeat_slow_ms  = wdata;
                REG_REPEAT_MID:   cfg_next.repeat_mid_ms   = wdata;
                REG_REPEAT_QUICK: cfg_next.repeat_quick_ms = wdata;
                REG_REPEAT_FAST:  cfg_next.repeat_fast_ms  = wdata;
                REG_REPEAT_TOP:   cfg_next.repeat_top_ms   = wdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DEBOUNCE:     rdata = cfg_reg.debounce_ms;
            REG_HOLD_DELAY:   rdata = cfg_reg.hold_delay_ms;
            REG_REPEAT_FIRST: rdata = cfg_reg.repeat_first_ms;
            REG_REPEAT_SLOW:  rdata = cfg_reg.repeat_slow_ms;
            REG_REPEAT_MID:   rdata = cfg_reg.repeat_mid_ms;
            REG_REPEAT_QUICK: rdata = cfg_reg.repeat_quick_ms;
            REG_REPEAT_FAST:  rdata = cfg_reg.repeat_fast_ms;
            REG_REPEAT_TOP:   rdata = cfg_reg.repeat_top_ms;
        endcase
    end

    assign prdata = {{(DataW-RegW){1'b0}}, rdata};
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms     <= 16'd50;
            cfg_reg.hold_delay_ms   <= 16'd1000;
            cfg_reg.repeat_first_ms <= 16'd600;
            cfg_reg.repeat_slow_ms  <= 16'd300;
            cfg_reg.repeat_mid_ms   <= 16'd250;
            cfg_reg.repeat_quick_ms <= 16'd180;
            cfg_reg.repeat_fast_ms  <= 16'd80;
            cfg_reg.repeat_top_ms   <= 16'd40;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/bcar_in_stage.sv -----
// Input register for the tick stream: holds one accepted beat until the core takes it.
// Depends on bcar_pkg for the tick struct.
module bcar_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  button_level,
    output bcar_pkg::bcar_tick_t  tick,
    input  logic                  tick_ready
);
    import bcar_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic level_reg;
    logic level_next;
    logic s_accept;

    assign s_tready = !valid_reg || tick_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        level_next = level_reg;
        if (s_accept) begin
            valid_next = 1'b1;
            level_next = button_level;
        end else if (tick_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        level_reg <= level_next;
    end

    assign tick.valid        = valid_reg;
    assign tick.button_level = level_reg;

endmodule

// ----- sv/bcar_tick_core.sv -----
// Per-tick debounce, first step and accelerating repeat, with the result register.
// Depends on bcar_pkg for the configuration struct, tick struct and segment tables.
module bcar_tick_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bcar_pkg::bcar_cfg_t         cfg,
    input  bcar_pkg::bcar_tick_t        tick,
    output logic                        tick_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bcar_pkg::CountW-1:0] count_value,
    output logic [bcar_pkg::SegW-1:0]   tens_segments,
    output logic [bcar_pkg::SegW-1:0]   ones_segments,
    output logic                        button_pressed
);
    import bcar_pkg::*;

    logic [TimeW-1:0]  time_reg,           time_next;
    logic [TimeW-1:0]  debounce_start_reg, debounce_start_next;
    logic [TimeW-1:0]  press_start_reg,    press_start_next;
    logic [TimeW-1:0]  last_repeat_reg,    last_repeat_next;
    logic              debounced_reg,      debounced_next;
    logic              step_taken_reg,     step_taken_next;
    logic [HoldW-1:0]  hold_level_reg,     hold_level_next;
    logic [CountW-1:0] counter_reg,        counter_next;

    logic              m_valid_reg,        m_valid_next;
    logic [CountW-1:0] count_reg;
    logic [SegW-1:0]   tens_reg;
    logic [SegW-1:0]   ones_reg;
    logic              pressed_reg;

    logic              advance;
    logic [TimeW-1:0]  debounce_diff;
    logic [TimeW-1:0]  held;
    logic [TimeW-1:0]  repeat_diff;
    logic [RegW-1:0]   interval;
    logic              first_step;
    logic              repeat_fire;
    logic [HoldW-1:0]  hold_mid;
    logic [CountW:0]   sum;

    assign tick_ready = !m_valid_reg || m_ready;
    assign advance    = tick.valid && tick_ready;

    always_comb begin
        case (hold_level_reg) inside
            5'd0:          interval = cfg.repeat_first_ms;
            [5'd1:5'd2]:   interval = cfg.repeat_slow_ms;
            [5'd3:5'd6]:   interval = cfg.repeat_mid_ms;
            [5'd7:5'd14]:  interval = cfg.repeat_quick_ms;
            [5'd15:5'd30]: interval = cfg.repeat_fast_ms;
            default:       interval = cfg.repeat_top_ms;
        endcase
    end

    always_comb begin
        debounce_diff       = time_reg - debounce_start_reg;
        held                = time_reg - press_start_reg;
        repeat_diff         = time_reg - last_repeat_reg;

        debounce_start_next = debounce_start_reg;
        debounced_next      = debounced_reg;
        if (!tick.button_level) begin
            debounce_start_next = time_reg;
            debounced_next      = 1'b0;
        end else if (debounce_diff > {{(TimeW-RegW){1'b0}}, cfg.debounce_ms}) begin
            debounced_next = 1'b1;
        end

        first_step       = !step_taken_reg && debounced_next;
        press_start_next = press_start_reg;
        hold_mid         = hold_level_reg;
        if (!first_step && !debounced_next) begin
            press_start_next = time_reg;
            hold_mid         = '0;
        end
        step_taken_next = debounced_next && (step_taken_reg || first_step);

        repeat_fire = step_taken_next && debounced_next
                      && (held > {{(TimeW-RegW){1'b0}}, cfg.hold_delay_ms})
                      && (repeat_diff > {{(TimeW-RegW){1'b0}}, interval});

        last_repeat_next = last_repeat_reg;
        hold_level_next  = hold_mid;
        if (repeat_fire) begin
            last_repeat_next = time_reg;
            if (hold_mid < HoldMax) begin
                hold_level_next = hold_mid + 1'b1;
            end
        end

        sum = {1'b0, counter_reg} + {{CountW{1'b0}}, first_step}
              + {{CountW{1'b0}}, repeat_fire};
        counter_next = (sum > CountMax) ? '0 : sum[CountW-1:0];
        time_next    = time_reg + 1'b1;

        m_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg           <= '0;
            debounce_start_reg <= '0;
            press_start_reg    <= '0;
            last_repeat_reg    <= '0;
            debounced_reg      <= 1'b0;
            step_taken_reg     <= 1'b0;
            hold_level_reg     <= '0;
            counter_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                time_reg           <= time_next;
                debounce_start_reg <= debounce_start_next;
                press_start_reg    <= press_start_next;
                last_repeat_reg    <= last_repeat_next;
                debounced_reg      <= debounced_next;
                step_taken_reg     <= step_taken_next;
                hold_level_reg     <= hold_level_next;
                counter_reg        <= counter_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            count_reg   <= counter_next;
            tens_reg    <= seg_of(tens_of(counter_next));
            ones_reg    <= seg_of(ones_of(counter_next));
            pressed_reg <= debounced_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign count_value    = count_reg;
    assign tens_segments  = tens_reg;
    assign ones_segments  = ones_reg;
    assign button_pressed = pressed_reg;

    a_step_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        step_taken_reg |-> debounced_reg)
        else $error("first step flag set without a debounced press");

    a_time_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> time_reg == $past(time_reg) + 1'b1)
        else $error("tick time did not advance on a processed beat");

    a_time_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(time_reg))
        else $error("tick time moved without a processed beat");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (count_reg == counter_reg && pressed_reg == debounced_reg))
        else $error("pending result disagrees with the counter state");

    a_hold_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (hold_level_reg >= $past(hold_level_reg) || hold_level_reg == '0))
        else $error("hold level dropped without a release");

endmodule

// ----- sv/button_counter_with_accelerating_repeat_core.sv -----
// Top level of the pushbutton counter with debounce and accelerating auto-repeat.
// Instantiates bcar_cfg_regs, bcar_in_stage and bcar_tick_core; uses bcar_pkg.
//
//   Channel   Direction  Beat contents
//   s_*       in         one millisecond tick: raw button level
//   m_*       out        count, tens and ones segment patterns, debounced state
//   APB       in/out     eight 16-bit timing registers at byte addresses 0x00..0x1C
//
// Each accepted beat passes through the input register and then the result register; the
// block sustains one beat per cycle while m_tready is high, set by the state update loop.
// Reset is synchronous and active low; it clears the valid flags and counter state and loads the default timings.
// When m_tready is low the result register and one input beat are held, and s_tready
// drops only when both are occupied.
module button_counter_with_accelerating_repeat_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bcar_pkg::InTdataW-1:0] s_tdata,   // [0] button_level
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bcar_pkg::OutTdataW-1:0] m_tdata,  // [5:0] count_value,
                                                     // [12:6] tens_segments,
                                                     // [19:13] ones_segments,
                                                     // [20] button_pressed
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcar_pkg::AddrW-1:0]    paddr,
    input  logic [bcar_pkg::DataW-1:0]    pwdata,
    output logic [bcar_pkg::DataW-1:0]    prdata,
    output logic                          pready
);
    import bcar_pkg::*;

    bcar_cfg_t         cfg;
    bcar_tick_t        tick;
    logic              tick_ready;
    logic [CountW-1:0] count_value;
    logic [SegW-1:0]   tens_segments;
    logic [SegW-1:0]   ones_segments;
    logic              button_pressed;

    bcar_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcar_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .button_level (s_tdata[0]),
        .tick         (tick),
        .tick_ready   (tick_ready)
    );

    bcar_tick_core u_tick_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .tick           (tick),
        .tick_ready     (tick_ready),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .count_value    (count_value),
        .tens_segments  (tens_segments),
        .ones_segments  (ones_segments),
        .button_pressed (button_pressed)
    );

    assign m_tdata = {{(OutTdataW - CountW - 2*SegW - 1){1'b0}},
                      button_pressed, ones_segments, tens_segments, count_value};

endmodule

// ----- bench/tb_button_counter_with_accelerating_repeat_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for button_counter_with_accelerating_repeat_core. It streams millisecond
// button ticks, predicts every readout beat and programs the timings over APB.
// Depends on bcar_pkg and the core's RTL.
module tb_button_counter_with_accelerating_repeat_core;
    import bcar_pkg::*;

    typedef struct packed {
        logic              pressed;
        logic [SegW-1:0]   ones_seg;
        logic [SegW-1:0]   tens_seg;
        logic [CountW-1:0] count;
    } readout_t;

    localparam logic [10:0] ZeroTimingBurst = 11'b01101011110;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [InTdataW-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OutTdataW-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [AddrW-1:0]      paddr    = '0;
    logic [DataW-1:0]      pwdata   = '0;
    logic [DataW-1:0]      prdata;
    logic                  pready;

    logic [RegW-1:0]   timing [CfgRegs];
    logic [TimeW-1:0]  clock_ms       = '0;
    logic [TimeW-1:0]  last_low       = '0;
    logic [TimeW-1:0]  last_release   = '0;
    logic [TimeW-1:0]  last_repeat_ms = '0;
    logic              settled        = 1'b0;
    logic              stepped        = 1'b0;
    logic [HoldW-1:0]  hold_lvl       = '0;
    logic [CountW-1:0] tally          = '0;

    logic     level_q [$];
    readout_t readout_q [$];

    int  errors       = 0;
    int  checked      = 0;
    int  settings     = 0;
    int  ticks_queued = 0;
    int  wraps        = 0;
    int  double_steps = 0;
    int  peak_hold    = 0;
    int  send_wait    = 0;
    int  recv_wait    = 0;
    int  long_hold    = 0;
    bit  gaps_on      = 1'b1;
    bit  stalled_once = 1'b0;

    button_counter_with_accelerating_repeat_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [SegW-1:0] glyph_of(input int digit);
        case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h6F;
            default: return '0;
        endcase
    endfunction

    // Advances the debounce, step and repeat state by one millisecond tick.
    function automatic readout_t predict_tick(input logic level);
        logic [TimeW-1:0]  now;
        logic [TimeW-1:0]  held;
        logic [TimeW-1:0]  interval;
        logic [CountW:0]   sum;
        int                steps;
        readout_t          r;
        now   = clock_ms;
        sum   = {1'b0, tally};
        steps = 0;
        if (!level) begin
            last_low = now;
            settled  = 1'b0;
        end else if (now - last_low > TimeW'(timing[REG_DEBOUNCE])) begin
            settled = 1'b1;
        end
        held = now - last_release;
        if (!stepped && settled) begin
            stepped = 1'b1;
            sum     = sum + 1'b1;
            steps++;
        end else if (!settled) begin
            last_release = now;
            hold_lvl     = '0;
        end
        if (!settled) begin
            stepped = 1'b0;
        end
        if (hold_lvl == 0) begin
            interval = TimeW'(timing[REG_REPEAT_FIRST]);
        end else if (hold_lvl <= 2) begin
            interval = TimeW'(timing[REG_REPEAT_SLOW]);
        end else if (hold_lvl <= 6) begin
            interval = TimeW'(timing[REG_REPEAT_MID]);
        end else if (hold_lvl <= 14) begin
            interval = TimeW'(timing[REG_REPEAT_QUICK]);
        end else if (hold_lvl <= 30) begin
            interval = TimeW'(timing[REG_REPEAT_FAST]);
        end else begin
            interval = TimeW'(timing[REG_REPEAT_TOP]);
        end
        if (stepped && settled && held > TimeW'(timing[REG_HOLD_DELAY]) &&
            now - last_repeat_ms > interval) begin
            last_repeat_ms = now;
            if (hold_lvl != HoldMax) begin
                hold_lvl = hold_lvl + 1'b1;
            end
            sum = sum + 1'b1;
            steps++;
        end
        if (steps == 2) begin
            double_steps++;
        end
        if (int'(hold_lvl) > peak_hold) begin
            peak_hold = int'(hold_lvl);
        end
        if (sum > CountMax) begin
            wraps++;
            tally = '0;
        end else begin
            tally = sum[CountW-1:0];
        end
        clock_ms   = now + 1'b1;
        r.count    = tally;
        r.tens_seg = glyph_of(int'(tally) / 10);
        r.ones_seg = glyph_of(int'(tally) % 10);
        r.pressed  = settled;
        return r;
    endfunction

    function automatic logic [RegW-1:0] draw_timing(input int small_top);
        case ($urandom_range(9))
            0:       return '0;
            9:       return '1;
            7, 8:    return RegW'($urandom_range(small_top * 4, small_top + 1));
            default: return RegW'($urandom_range(small_top, 1));
        endcase
    endfunction

    task automatic write_timing(input bcar_reg_idx_t idx, input logic [RegW-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        timing[idx] = value;
    endtask

    task automatic check_timings();
        int i;
        for (i = 0; i < CfgRegs; i++) begin
            @(posedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(i), 2'b00};
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            if (prdata !== {16'h0000, timing[i]}) begin
                $display("%0t: register %0d readback: expected %h, got %h",
                         $time, i, {16'h0000, timing[i]}, prdata);
                errors++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic queue_press(input int low_len, input int high_len, input int bounce_pct);
        int k;
        for (k = 0; k < low_len; k++) begin
            level_q.push_back(1'b0);
        end
        for (k = 0; k < high_len; k++) begin
            level_q.push_back($urandom_range(99) >= bounce_pct);
        end
        ticks_queued += low_len + high_len;
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (level_q.size() != 0 || s_tvalid || readout_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                readout_q.push_back(predict_tick(s_tdata[0]));
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (level_q.size() != 0) begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {{(InTdataW-1){1'b0}}, level_q.pop_front()};
                    send_wait <= gaps_on ? $urandom_range(4) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : readout_check
        readout_t got;
        readout_t want;
        int       draw;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
            long_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = readout_t'(m_tdata[$bits(readout_t)-1:0]);
                if (readout_q.size() == 0) begin
                    $display("%0t: readout beat with nothing expected: got %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = readout_q.pop_front();
                    checked++;
                    if (got.count !== want.count) begin
                        $display("%0t: count: expected %0d, got %0d",
                                 $time, want.count, got.count);
                        errors++;
                    end
                    if (got.tens_seg !== want.tens_seg) begin
                        $display("%0t: tens segments: expected %h, got %h",
                                 $time, want.tens_seg, got.tens_seg);
                        errors++;
                    end
                    if (got.ones_seg !== want.ones_seg) begin
                        $display("%0t: ones segments: expected %h, got %h",
                                 $time, want.ones_seg, got.ones_seg);
                        errors++;
                    end
                    if (got.pressed !== want.pressed) begin
                        $display("%0t: pressed: expected %b, got %b",
                                 $time, want.pressed, got.pressed);
                        errors++;
                    end
                end
            end
            // One long stall while ticks keep coming, so the core backs up into its input.
            if (long_hold > 0) begin
                long_hold <= long_hold - 1;
                m_tready  <= 1'b0;
            end else if (!stalled_once && checked >= 100 && level_q.size() > 8) begin
                stalled_once <= 1'b1;
                long_hold    <= 60;
                m_tready     <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_tready  <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                draw = gaps_on ? $urandom_range(4) : 0;
                if (draw > 0) begin
                    recv_wait <= draw - 1;
                end
                m_tready <= (draw == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d readouts outstanding", readout_q.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        int i;
        int phase;
        int presses;
        int bounce;
        timing = '{16'd50, 16'd1000, 16'd600, 16'd300, 16'd250, 16'd180, 16'd80, 16'd40};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_timings();
        settings++;
        level_q.push_back(1'b1);
        level_q.push_back(1'b0);
        level_q.push_back(1'b1);
        ticks_queued += 3;
        wait_idle();

        // With every timing at zero the first debounced tick of a press both steps and repeats.
        for (i = 0; i < CfgRegs; i++) begin
            write_timing(bcar_reg_idx_t'(i), '0);
        end
        check_timings();
        settings++;
        for (i = 0; i < 11; i++) begin
            level_q.push_back(ZeroTimingBurst[i]);
        end
        ticks_queued += 11;
        wait_idle();

        for (i = 0; i < CfgRegs; i++) begin
            write_timing(bcar_reg_idx_t'(i), '1);
        end
        check_timings();
        settings++;
        queue_press(1, 5, 0);
        wait_idle();

        phase = 0;
        while (ticks_queued < 480) begin
            if (phase == 0) begin
                for (i = 0; i < CfgRegs; i++) begin
                    write_timing(bcar_reg_idx_t'(i), '0);
                end
                write_timing(REG_DEBOUNCE, 16'd1);
                write_timing(REG_HOLD_DELAY, 16'd2);
                write_timing(REG_REPEAT_TOP, 16'd1);
            end else begin
                write_timing(REG_DEBOUNCE, draw_timing(4));
                write_timing(REG_HOLD_DELAY, draw_timing(20));
                for (i = REG_REPEAT_FIRST; i < CfgRegs; i++) begin
                    write_timing(bcar_reg_idx_t'(i), draw_timing(6));
                end
            end
            check_timings();
            settings++;
            gaps_on = ($urandom_range(3) != 0);
            bounce  = ($urandom_range(3) == 0) ? 8 : 0;
            if (phase == 0) begin
                queue_press(2, 80, 0);
            end
            presses = $urandom_range(6, 3);
            for (i = 0; i < presses; i++) begin
                queue_press($urandom_range(8, 1),
                            ($urandom_range(3) == 0) ? $urandom_range(90, 40)
                                                     : $urandom_range(30, 1),
                            bounce);
            end
            wait_idle();
            phase++;
        end

        repeat (10) @(posedge aclk);
        if (readout_q.size() != 0) begin
            $display("%0t: %0d readouts never arrived", $time, readout_q.size());
            errors++;
        end
        $display("Checked %0d readout beats under %0d timing settings.", checked, settings);
        $display("Saw %0d counter wraps, %0d double-step ticks, hold level up to %0d.",
                 wraps, double_steps, peak_hold);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/bcar_pkg.sv
sv/bcar_cfg_regs.sv
sv/bcar_in_stage.sv
sv/bcar_tick_core.sv
sv/button_counter_with_accelerating_repeat_core.sv
bench/tb_button_counter_with_accelerating_repeat_core.sv
